// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the modulator pool.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on i_clk and off while reset is held.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and off while reset is held.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mpll_pkg.sv =====
// Types and constants of the leaky modulator pool.
package mpll_pkg;

    localparam int MAX_CH    = 4;
    localparam int LANE_W    = 16;
    localparam int CUR_W     = 15;

    typedef logic signed [LANE_W-1:0] t_level;
    typedef logic [CUR_W-1:0]         t_cur;

    // Item actions.
    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_RELEASE   = 3'd1,
        ACT_EXCITE    = 3'd2,
        ACT_INHIBIT   = 3'd3,
        ACT_SALIENCE  = 3'd4,
        ACT_SET_TONIC = 3'd5,
        ACT_READ      = 3'd6
    } t_action;

    // Configuration register indexes (one per 8-byte slot).
    typedef enum logic [2:0] {
        REG_BASAL = 3'd0,
        REG_MAX   = 3'd1,
        REG_DECAY = 3'd2,
        REG_DRIFT = 3'd3,
        REG_XMOD  = 3'd4
    } t_reg_idx;

    // Register reset values.
    localparam logic [63:0] BASAL_RST = 64'd230533284548183245;
    localparam logic [63:0] MAX_RST   = 64'd1152939097061330944;
    localparam logic [63:0] DECAY_RST = 64'd9223512776490647552;
    localparam logic [15:0] DRIFT_RST = 16'd7;
    localparam logic        XMOD_RST  = 1'b1;

    // Fixed-point constants: 0.7 in Q3.12, 0.1 in Q3.12, 0.05 and 0.03 in Q0.16.
    localparam t_cur               NE_THRESHOLD = 15'd2867;
    localparam logic signed [15:0] STEP_TENTH   = 16'sd410;
    localparam logic signed [16:0] SAL_ACH_Q16  = 17'sd3277;
    localparam logic signed [16:0] SAL_NE_Q16   = 17'sd1966;

endpackage

// ===== hw/rtl/mpll_in_if.sv =====
// Input item channel of the modulator pool.
interface mpll_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         action;
    logic [1:0]         channel;
    logic signed [15:0] amount;

    modport source (output valid, output action, output channel, output amount, input ready);
    modport sink   (input valid, input action, input channel, input amount, output ready);
endinterface

// ===== hw/rtl/mpll_out_if.sv =====
// Result item channel of the modulator pool.
interface mpll_out_if;
    logic               valid;
    logic               ready;
    logic [14:0]        level;
    logic signed [15:0] tonic_level;
    logic signed [15:0] phasic_level;
    logic [14:0]        peak_level;
    logic [14:0]        arousal;
    logic [15:0]        release_count;

    modport source (output valid, output level, output tonic_level, output phasic_level,
                    output peak_level, output arousal, output release_count, input ready);
    modport sink   (input valid, input level, input tonic_level, input phasic_level,
                    input peak_level, input arousal, input release_count, output ready);
endinterface

// ===== hw/rtl/modulator_pool_leaky_levels.sv =====
// Top level of the leaky modulator pool: channel state, update logic and result register.
// An input transfer has its result registered in the output register.
// Throughput: one item per cycle unless the output stalls; all channels update together.
// The input side stalls only while a result waits in the output register unaccepted.
// Reset (synchronous, active low) loads register defaults, tonic and current from basal.
`include "assert_macros.svh"

module modulator_pool_leaky_levels #(
    parameter int CHANNELS   = 4,
    parameter int LEVEL_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mpll_in_if.sink     i_in,
    mpll_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import mpll_pkg::*;

    localparam int AW = 40;
    localparam logic signed [AW-1:0] ONE  = 1;
    localparam logic signed [AW-1:0] LMAX = (ONE <<< (LEVEL_BITS - 1)) - ONE;
    localparam logic signed [AW-1:0] LMIN = -LMAX - ONE;

    // Round to nearest, ties upward: add half, then arithmetic shift.
    function automatic logic signed [AW-1:0] rshift(input logic signed [AW-1:0] v,
                                                    input int s);
        logic signed [AW-1:0] t;
        t = v + (ONE <<< (s - 1));
        return t >>> s;
    endfunction

    // Saturate to the signed level range.
    function automatic t_level sat(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] x;
        x = v;
        if (x > LMAX) x = LMAX;
        if (x < LMIN) x = LMIN;
        return x[LANE_W-1:0];
    endfunction

    // Clamp the current level to 0..max.
    function automatic t_cur clampc(input logic signed [AW-1:0] v,
                                    input logic signed [LANE_W-1:0] m);
        logic signed [AW-1:0] x;
        x = v;
        if (x > AW'(m)) x = AW'(m);
        if (x < 0) x = '0;
        return x[CUR_W-1:0];
    endfunction

    // Configuration registers.
    logic [63:0] r_basal, r_max, r_decay;
    logic [15:0] r_drift;
    logic        r_xmod;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_basal <= BASAL_RST;
            r_max   <= MAX_RST;
            r_decay <= DECAY_RST;
            r_drift <= DRIFT_RST;
            r_xmod  <= XMOD_RST;
        end else if (cfg_wr) begin
            case (t_reg_idx'(paddr[5:3]))
                REG_BASAL: r_basal <= pwdata;
                REG_MAX:   r_max   <= pwdata;
                REG_DECAY: r_decay <= pwdata;
                REG_DRIFT: r_drift <= pwdata[15:0];
                REG_XMOD:  r_xmod  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (t_reg_idx'(paddr[5:3]))
            REG_BASAL: prdata = r_basal;
            REG_MAX:   prdata = r_max;
            REG_DECAY: prdata = r_decay;
            REG_DRIFT: prdata = {48'd0, r_drift};
            REG_XMOD:  prdata = {63'd0, r_xmod};
            default:   prdata = '0;
        endcase
    end

    // Channel state.
    logic signed [LEVEL_BITS-1:0] r_tonic  [CHANNELS];
    logic signed [LEVEL_BITS-1:0] r_phasic [CHANNELS];
    t_cur                         r_cur    [CHANNELS];
    t_cur                         r_peak   [CHANNELS];
    logic [15:0]                  r_rel    [CHANNELS];
    logic [31:0]                  r_tick_cnt, r_event_cnt;
    logic [31:0]                  n_tick_cnt, n_event_cnt;

    // Full-width views of the state; missing channels read as zero.
    t_level      tonic_q [MAX_CH];
    t_level      phasic_q[MAX_CH];
    t_cur        cur_q   [MAX_CH];
    t_cur        peak_q  [MAX_CH];
    logic [15:0] rel_q   [MAX_CH];

    for (genvar g = 0; g < MAX_CH; g++) begin : g_view
        if (g < CHANNELS) begin : g_live
            assign tonic_q[g]  = LANE_W'(r_tonic[g]);
            assign phasic_q[g] = LANE_W'(r_phasic[g]);
            assign cur_q[g]    = r_cur[g];
            assign peak_q[g]   = r_peak[g];
            assign rel_q[g]    = r_rel[g];
        end else begin : g_none
            assign tonic_q[g]  = '0;
            assign phasic_q[g] = '0;
            assign cur_q[g]    = '0;
            assign peak_q[g]   = '0;
            assign rel_q[g]    = '0;
        end
    end

    // Handshake and output register.
    logic   in_ready, acc, is_tick;
    logic   r_out_valid;
    t_cur   r_out_level, r_out_peak, r_out_arousal;
    t_level r_out_tonic, r_out_phasic;
    logic [15:0] r_out_rel;

    assign in_ready   = !r_out_valid || o_out.ready;
    assign acc        = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // Update logic for all channels.
    t_action              act;
    logic signed [32:0]   pm, ach_prod, ne_prod;
    logic signed [17:0]   gap;
    logic signed [34:0]   gm;
    logic signed [AW-1:0] sp, ach_add, ne_add;
    logic signed [AW-1:0] add_amt[MAX_CH];
    logic                 hit[MAX_CH];
    t_level               tk_t[MAX_CH], tk_p[MAX_CH], ev_p[MAX_CH];
    t_cur                 tk_c[MAX_CH], tk_pk[MAX_CH];
    logic                 sup_on;
    t_level               n_tonic[MAX_CH], n_phasic[MAX_CH];
    t_cur                 n_cur[MAX_CH], n_peak[MAX_CH];
    logic [15:0]          n_rel[MAX_CH];
    t_cur                 sel_level, sel_peak, c2, c3;
    t_level               sel_tonic, sel_phasic;
    logic [15:0]          sel_rel, ar_sum;

    assign act     = t_action'(i_in.action);
    assign is_tick = (act == ACT_TICK);

    always_comb begin
        // Tick: phasic decay, tonic drift, clamp and peak per lane.
        for (int i = 0; i < MAX_CH; i++) begin
            pm       = phasic_q[i] * $signed({1'b0, r_decay[16*i +: 16]});
            tk_p[i]  = sat(rshift(AW'(pm), 15));
            gap      = 18'($signed(r_basal[16*i +: 16])) - 18'(tonic_q[i]);
            gm       = gap * $signed({1'b0, r_drift});
            tk_t[i]  = sat(AW'(tonic_q[i]) + rshift(AW'(gm), 16));
            tk_c[i]  = clampc(AW'(tk_t[i]) + AW'(tk_p[i]), $signed(r_max[16*i +: 16]));
            tk_pk[i] = (tk_c[i] > peak_q[i]) ? tk_c[i] : peak_q[i];
        end

        // Serotonin suppression by 32440/32768 once norepinephrine is high.
        sup_on = r_xmod && (CHANNELS > 3) && (tk_c[3] > NE_THRESHOLD);
        sp = (AW'(tk_p[1]) <<< 15) - (AW'(tk_p[1]) <<< 8)
           - (AW'(tk_p[1]) <<< 6) - (AW'(tk_p[1]) <<< 3);
        if (sup_on) tk_p[1] = sat(rshift(sp, 15));

        // Event amounts per lane.
        ach_prod = i_in.amount * SAL_ACH_Q16;
        ne_prod  = i_in.amount * SAL_NE_Q16;
        ach_add  = rshift(AW'(ach_prod), 16);
        ne_add   = rshift(AW'(ne_prod), 16);
        for (int i = 0; i < MAX_CH; i++) begin
            hit[i]     = 1'b0;
            add_amt[i] = '0;
        end
        case (act)
            ACT_RELEASE: begin
                for (int i = 0; i < MAX_CH; i++) begin
                    if (i_in.channel == 2'(i)) begin
                        hit[i]     = 1'b1;
                        add_amt[i] = AW'(i_in.amount);
                    end
                end
            end
            ACT_EXCITE: begin
                hit[0]     = 1'b1;
                add_amt[0] = AW'(STEP_TENTH);
            end
            ACT_INHIBIT: begin
                hit[1]     = 1'b1;
                add_amt[1] = AW'(STEP_TENTH);
            end
            ACT_SALIENCE: begin
                hit[2]     = 1'b1;
                add_amt[2] = ach_add;
                hit[3]     = 1'b1;
                add_amt[3] = ne_add;
            end
            default: ;
        endcase

        // Next state per lane.
        for (int i = 0; i < MAX_CH; i++) begin
            ev_p[i]     = sat(AW'(phasic_q[i]) + add_amt[i]);
            n_tonic[i]  = tonic_q[i];
            n_phasic[i] = phasic_q[i];
            n_cur[i]    = cur_q[i];
            n_peak[i]   = peak_q[i];
            n_rel[i]    = rel_q[i];
            case (act)
                ACT_TICK: begin
                    n_tonic[i]  = tk_t[i];
                    n_phasic[i] = tk_p[i];
                    n_cur[i]    = tk_c[i];
                    n_peak[i]   = tk_pk[i];
                end
                ACT_RELEASE, ACT_EXCITE, ACT_INHIBIT, ACT_SALIENCE: begin
                    if (hit[i]) begin
                        n_phasic[i] = ev_p[i];
                        if (rel_q[i] != 16'hFFFF) n_rel[i] = rel_q[i] + 16'd1;
                    end
                end
                ACT_SET_TONIC: begin
                    if (i_in.channel == 2'(i)) n_tonic[i] = sat(AW'(i_in.amount));
                end
                default: ;
            endcase
        end

        // Tick and event counters saturate.
        n_tick_cnt  = r_tick_cnt;
        n_event_cnt = r_event_cnt;
        if (is_tick && r_tick_cnt != 32'hFFFF_FFFF) n_tick_cnt = r_tick_cnt + 32'd1;
        if ((act == ACT_RELEASE || act == ACT_EXCITE || act == ACT_INHIBIT ||
             act == ACT_SALIENCE) && r_event_cnt != 32'hFFFF_FFFF)
            n_event_cnt = r_event_cnt + 32'd1;

        // Result of the chosen channel; a missing channel reports zeros.
        sel_level  = '0;
        sel_tonic  = '0;
        sel_phasic = '0;
        sel_peak   = '0;
        sel_rel    = '0;
        for (int i = 0; i < MAX_CH; i++) begin
            if (i < CHANNELS && i_in.channel == 2'(i)) begin
                sel_level  = n_cur[i];
                sel_tonic  = n_tonic[i];
                sel_phasic = n_phasic[i];
                sel_peak   = n_peak[i];
                sel_rel    = n_rel[i];
            end
        end
        c2     = (CHANNELS > 2) ? n_cur[2] : '0;
        c3     = (CHANNELS > 3) ? n_cur[3] : '0;
        ar_sum = 16'(c2) + 16'(c3);
    end

    // Channel state registers.
    for (genvar g = 0; g < CHANNELS; g++) begin : g_state
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tonic[g]  <= LEVEL_BITS'(sat(AW'($signed(BASAL_RST[16*g +: 16]))));
                r_phasic[g] <= '0;
                r_cur[g]    <= clampc(AW'(sat(AW'($signed(BASAL_RST[16*g +: 16])))),
                                      $signed(MAX_RST[16*g +: 16]));
                r_peak[g]   <= '0;
                r_rel[g]    <= '0;
            end else if (acc) begin
                r_tonic[g]  <= n_tonic[g][LEVEL_BITS-1:0];
                r_phasic[g] <= n_phasic[g][LEVEL_BITS-1:0];
                r_cur[g]    <= n_cur[g];
                r_peak[g]   <= n_peak[g];
                r_rel[g]    <= n_rel[g];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_cnt  <= '0;
            r_event_cnt <= '0;
        end else if (acc) begin
            r_tick_cnt  <= n_tick_cnt;
            r_event_cnt <= n_event_cnt;
        end
    end

    // Output register: loads on an input transfer, empties on an output transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out_level   <= sel_level;
            r_out_tonic   <= sel_tonic;
            r_out_phasic  <= sel_phasic;
            r_out_peak    <= sel_peak;
            r_out_rel     <= sel_rel;
            r_out_arousal <= ar_sum[15:1];
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.level         = r_out_level;
    assign o_out.tonic_level   = r_out_tonic;
    assign o_out.phasic_level  = r_out_phasic;
    assign o_out.peak_level    = r_out_peak;
    assign o_out.arousal       = r_out_arousal;
    assign o_out.release_count = r_out_rel;

    // Checks on the pipeline and the channel state.
    `ASSERT_IMPL(a_ready_when_empty, !r_out_valid, in_ready, "input stalled with empty output")
    `ASSERT_NEXT(a_accept_gives_result, acc, r_out_valid, "transfer produced no result")
    `ASSERT_IMPL(a_rel_no_decrease, $past(i_rst_n), r_rel[0] >= $past(r_rel[0]), "count fell")
    `ASSERT_IMPL(a_tick_peak, $past(acc && is_tick), r_out_peak >= r_out_level, "low peak")

endmodule
